// ===== sv/sbdf_pkg.sv =====
// Shared item types and iterative arithmetic unit interface for the slew-bounded derivative filter.
`default_nettype none

package sbdf_pkg;

  // Widths of the shared arithmetic unit operands and step counter.
  localparam int ALU_AW = 128;
  localparam int ALU_BW = 64;
  localparam int ALU_SW = 8;

  // Saturation bound of intermediate products and sums.
  localparam logic [63:0] SAT_LIM = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [31:0]        time_us;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_value;
    logic signed [31:0] derivative;
  } out_item_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  // Request to the shared unit: a*b (64 x 64) or a/b with a aligned to the top.
  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [ALU_AW-1:0] a;
    logic [ALU_BW-1:0] b;
    logic [ALU_SW-1:0] steps;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [ALU_AW-1:0] res;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== sv/sbdf_alu.sv =====
// Shared multi-cycle unit: 64x64 multiply by 32-bit partial products, restoring divide.
`default_nettype none

module sbdf_alu (
  input  logic              clk,
  input  logic              rst,
  input  sbdf_pkg::alu_req_t req,
  output sbdf_pkg::alu_rsp_t rsp
);
  import sbdf_pkg::*;

  logic              busy;
  logic              done;
  alu_op_t           op_q;
  logic [63:0]       a_q;
  logic [63:0]       b_q;
  logic [63:0]       rem;
  logic [63:0]       pp;
  logic [ALU_AW-1:0] acc;
  logic [ALU_SW-1:0] cnt;

  logic [1:0]        k;
  logic [31:0]       a_part;
  logic [31:0]       b_part;
  logic [ALU_AW-1:0] pp_sh;
  logic [64:0]       trial;
  logic              ge;

  // Partial product selection and one restoring divide step.
  always_comb begin
    k      = cnt[2:1];
    a_part = k[0] ? a_q[63:32] : a_q[31:0];
    b_part = k[1] ? b_q[63:32] : b_q[31:0];
    unique case (k)
      2'd0:    pp_sh = ALU_AW'(pp);
      2'd3:    pp_sh = ALU_AW'(pp) << 64;
      default: pp_sh = ALU_AW'(pp) << 32;
    endcase
    trial = {rem, acc[ALU_AW-1]};
    ge    = trial >= {1'b0, b_q};
  end

  // Even steps multiply, odd steps accumulate; division shifts one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_q <= req.op;
        b_q  <= req.b;
        a_q  <= req.a[63:0];
        rem  <= '0;
        if (req.op == ALU_DIV) begin
          acc <= req.a;
          cnt <= req.steps;
        end else begin
          acc <= '0;
          cnt <= '0;
        end
      end else if (busy) begin
        if (op_q == ALU_MUL) begin
          if (!cnt[0]) begin
            pp <= 64'(a_part) * 64'(b_part);
          end else begin
            acc <= acc + pp_sh;
          end
          if (cnt == ALU_SW'(7)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          cnt <= cnt + ALU_SW'(1);
        end else begin
          rem <= ge ? 64'(trial - {1'b0, b_q}) : trial[63:0];
          acc <= {acc[ALU_AW-2:0], ge};
          if (cnt == ALU_SW'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          cnt <= cnt - ALU_SW'(1);
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = acc;

`ifndef SYNTHESIS
  // A new operation only starts once the previous one has finished.
  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("operation started while busy");
  // The partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
      (busy && op_q == ALU_DIV) |-> (rem < b_q))
    else $error("remainder not below divisor");
  // Completion follows a busy cycle and releases the unit.
  a_done_end: assert property (@(posedge clk) disable iff (rst)
      rsp.done |-> (!busy && $past(busy)))
    else $error("done without a finished operation");
`endif

endmodule

`default_nettype wire

// ===== sv/slew_bounded_derivative_filter.sv =====
// Top level of the slew-bounded derivative filter: sequencer, state and configuration.
// The first sample and a non-positive time step give their result in the cycle after the item.
// A full update runs 18 multiplies and 2 divides on the shared unit, plus a clamp divide and
// one multiply per whole time constant in exp; a step of 64 time constants or more skips exp.
// One item is worked on at a time. Synchronous reset restores the register defaults.
`default_nettype none

module slew_bounded_derivative_filter #(
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [30:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sbdf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbdf_pkg::out_item_t  out_data
);
  import sbdf_pkg::*;

  localparam int EXP_Q = 30;
  localparam int IDXW  = $clog2(EXP_TABLE_DEPTH);
  localparam int TAUW  = 31 + FRAC_BITS;
  localparam logic [63:0] ONE     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TAU_MAX = 64'd64 << FRAC_BITS;
  localparam logic [31:0] RND     = 32'd1 << (EXP_Q - FRAC_BITS - 1);
  localparam logic [63:0] US_PER_S = 64'd1000000;
  localparam logic [1:0] REG_RISE   = 2'd0;
  localparam logic [1:0] REG_FALL   = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  // Division by a constant as a multiply by its reciprocal, rounded up. Each shift leaves
  // enough headroom over the operand range for the product to give the exact floor.
  localparam int R_SH   = EXP_Q + IDXW;
  localparam int SIX_SH = EXP_Q + 4;
  localparam int US_SH  = FRAC_BITS + 52;
  localparam logic [63:0] R_RCP =
    64'(((128'd1 << R_SH) + 128'(EXP_TABLE_DEPTH) - 128'd1) / 128'(EXP_TABLE_DEPTH));
  localparam logic [63:0] SIX_RCP = 64'(((128'd1 << SIX_SH) + 128'd5) / 128'd6);
  localparam logic [63:0] US_RCP =
    64'(((128'd1 << US_SH) + 128'(US_PER_S) - 128'd1) / 128'(US_PER_S));

  typedef logic [EXP_Q:0] rom_arr_t [EXP_TABLE_DEPTH+1];

  // exp(-k/DEPTH) in Q30 from a truncated Taylor sum of 25 terms.
  function automatic rom_arr_t build_rom();
    rom_arr_t           tbl;
    logic [63:0]        xk;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      xk   = (64'(k) << EXP_Q) / 64'(EXP_TABLE_DEPTH);
      term = 64'd1 << EXP_Q;
      sum  = $signed(term);
      for (int j = 1; j <= 24; j++) begin
        term = ((term * xk) >> EXP_Q) / 64'(j);
        if ((j & 1) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      tbl[k] = sum[EXP_Q:0];
    end
    return tbl;
  endfunction

  localparam rom_arr_t EXP_ROM = build_rom();
  localparam logic [EXP_Q:0] ROM_ONE = EXP_ROM[EXP_TABLE_DEPTH];

  function automatic logic signed [63:0] sadd62(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] sum;
    sum = 65'(a) + 65'(b);
    if (sum > $signed({1'b0, SAT_LIM})) begin
      return $signed(SAT_LIM);
    end else if (sum < -$signed({1'b0, SAT_LIM})) begin
      return -$signed(SAT_LIM);
    end
    return sum[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    if (a > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (a < -64'sh8000_0000) begin
      return -32'sh8000_0000;
    end
    return a[31:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE, ST_TAU, ST_FD, ST_R, ST_R2, ST_R3, ST_R6, ST_M0, ST_MLOOP,
    ST_P, ST_S, ST_G1, ST_G2, ST_G3, ST_H1, ST_H2,
    ST_W1, ST_W2, ST_W3, ST_CLAMP, ST_UDIV, ST_X1, ST_X2, ST_X3, ST_DONE
  } state_t;

  state_t state;

  // Configuration and filter state.
  logic [30:0]        rise_limit;
  logic [30:0]        fall_limit;
  logic [23:0]        period_us;
  logic               started;
  logic [31:0]        last_time;
  logic signed [31:0] state_value;
  logic signed [31:0] state_slope;

  // Working registers of one update.
  logic signed [31:0] u;
  logic signed [31:0] x;
  logic signed [31:0] v;
  logic [30:0]        dt;
  logic [23:0]        per;
  logic signed [31:0] lim_lo;
  logic signed [31:0] lim_hi;
  logic [TAUW-1:0]    tau;
  logic [5:0]         n;
  logic [FRAC_BITS-1:0] fdf;
  logic [IDXW-1:0]    idx;
  logic [29:0]        r;
  logic [29:0]        r2;
  logic [29:0]        r3;
  logic [EXP_Q:0]     poly;
  logic [EXP_Q:0]     rom_q;
  logic [EXP_Q:0]     m;
  logic [FRAC_BITS:0] e;
  logic signed [63:0] p;
  logic signed [63:0] s;
  logic signed [63:0] g;
  logic signed [63:0] h;
  logic [63:0]        tmp;
  logic signed [63:0] acc;
  logic signed [63:0] vfree;
  logic signed [63:0] un;
  logic signed [63:0] vn;
  logic [63:0]        dnum;
  logic               clamp_sub;
  logic               issued;
  logic               alu_start;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Operand selection and result decoding.
  logic               use_w;
  logic signed [63:0] wa;
  logic signed [63:0] wb;
  logic               wneg;
  logic [ALU_AW-1:0]  wq;
  logic [63:0]        wsat;
  logic signed [63:0] wres;
  logic [63:0]        prod_sh;
  logic [EXP_Q:0]     m_res;
  logic [31:0]        e_sum;
  logic [FRAC_BITS:0] e_new;
  logic [63:0]        qsat;
  logic [31:0]        dt_raw;

  sbdf_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Operands of the shared unit for each step of the sequence.
  always_comb begin
    alu_req.start = alu_start;
    alu_req.op    = ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    alu_req.steps = ALU_SW'(64);
    use_w         = 1'b0;
    wa            = '0;
    wb            = '0;
    unique case (state)
      ST_TAU: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = {64'(dt) << FRAC_BITS, 64'd0};
        alu_req.b  = 64'(per);
      end
      ST_FD: begin
        alu_req.a = ALU_AW'(tau[FRAC_BITS-1:0]);
        alu_req.b = 64'(EXP_TABLE_DEPTH);
      end
      ST_R: begin
        alu_req.a = ALU_AW'(64'(fdf) << (EXP_Q - FRAC_BITS));
        alu_req.b = R_RCP;
      end
      ST_R2: begin
        alu_req.a = ALU_AW'(r);
        alu_req.b = 64'(r);
      end
      ST_R3: begin
        alu_req.a = ALU_AW'(r2);
        alu_req.b = 64'(r);
      end
      ST_R6: begin
        alu_req.a = ALU_AW'(r3);
        alu_req.b = SIX_RCP;
      end
      ST_M0: begin
        alu_req.a = ALU_AW'(rom_q);
        alu_req.b = 64'(poly);
      end
      ST_MLOOP: begin
        alu_req.a = ALU_AW'(m);
        alu_req.b = 64'(ROM_ONE);
      end
      ST_P: begin
        alu_req.a = ALU_AW'(e);
        alu_req.b = ONE + 64'(tau);
      end
      ST_S: begin
        alu_req.a = ALU_AW'(e);
        alu_req.b = (64'(tau) > ONE) ? 64'(tau) - ONE : ONE - 64'(tau);
      end
      ST_G1: begin
        alu_req.a = ALU_AW'(tau);
        alu_req.b = 64'(e);
      end
      ST_G2: begin
        alu_req.a = ALU_AW'(tmp);
        alu_req.b = US_PER_S;
      end
      ST_G3: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = {tmp, 64'd0};
        alu_req.b  = 64'(per);
      end
      ST_H1: begin
        alu_req.a = ALU_AW'(e);
        alu_req.b = 64'(dt);
      end
      ST_H2: begin
        alu_req.a = ALU_AW'(tmp);
        alu_req.b = US_RCP;
      end
      ST_W1: begin
        use_w = 1'b1;
        wa    = g;
        wb    = -64'(x);
      end
      ST_W2: begin
        use_w = 1'b1;
        wa    = s;
        wb    = 64'(v);
      end
      ST_W3: begin
        use_w = 1'b1;
        wa    = g;
        wb    = 64'(u);
      end
      ST_UDIV: begin
        alu_req.op    = ALU_DIV;
        alu_req.a     = ALU_AW'(dnum) << FRAC_BITS;
        alu_req.b     = 64'(g);
        alu_req.steps = ALU_SW'(128);
      end
      ST_X1: begin
        use_w = 1'b1;
        wa    = p;
        wb    = 64'(x);
      end
      ST_X2: begin
        use_w = 1'b1;
        wa    = h;
        wb    = 64'(v);
      end
      ST_X3: begin
        use_w = 1'b1;
        wa    = $signed(ONE) - p;
        wb    = un;
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
    if (use_w) begin
      alu_req.a = ALU_AW'(mag64(wa));
      alu_req.b = mag64(wb);
    end

    // Signed fixed-point product: truncate toward zero, saturate to 2^62.
    wneg    = wa[63] ^ wb[63];
    wq      = alu_rsp.res >> FRAC_BITS;
    wsat    = (wq > ALU_AW'(SAT_LIM)) ? SAT_LIM : wq[63:0];
    wres    = wneg ? -$signed(wsat) : $signed(wsat);
    prod_sh = alu_rsp.res[FRAC_BITS +: 64];
    m_res   = alu_rsp.res[EXP_Q +: EXP_Q+1];
    e_sum   = 32'(m_res) + RND;
    e_new   = e_sum[(EXP_Q - FRAC_BITS) +: FRAC_BITS+1];
    qsat    = (alu_rsp.res > ALU_AW'(SAT_LIM)) ? SAT_LIM : alu_rsp.res[63:0];
    dt_raw  = in_data.time_us - last_time;
  end

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);

  // Sequencer, filter state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rise_limit  <= 31'd65536;
      fall_limit  <= 31'd65536;
      period_us   <= 24'd1000;
      started     <= 1'b0;
      last_time   <= '0;
      state_value <= '0;
      state_slope <= '0;
      issued      <= 1'b0;
      alu_start   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      alu_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Register writes.
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_RISE:   rise_limit <= cfg_data;
          REG_FALL:   fall_limit <= cfg_data;
          REG_PERIOD: period_us  <= cfg_data[23:0];
          default:    rise_limit <= rise_limit;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            last_time <= in_data.time_us;
            if (!started) begin
              started                 <= 1'b1;
              state_value             <= in_data.sample;
              state_slope             <= '0;
              out_data.filtered_value <= in_data.sample;
              out_data.derivative     <= '0;
              out_valid               <= 1'b1;
            end else if (dt_raw[31] || dt_raw == 32'd0) begin
              out_data.filtered_value <= state_value;
              out_data.derivative     <= state_slope;
              out_valid               <= 1'b1;
            end else begin
              dt  <= dt_raw[30:0];
              u   <= in_data.sample;
              x   <= state_value;
              v   <= state_slope;
              per <= (period_us == 24'd0) ? 24'd1 : period_us;
              if (!state_value[31]) begin
                lim_lo <= -$signed({1'b0, fall_limit});
                lim_hi <= $signed({1'b0, rise_limit});
              end else begin
                lim_lo <= -$signed({1'b0, rise_limit});
                lim_hi <= $signed({1'b0, fall_limit});
              end
              state <= ST_TAU;
            end
          end
        end

        // Clamp the input so the new derivative stays inside the limits, when g is nonzero.
        ST_CLAMP: begin
          if (g != 0 && vfree > 64'(lim_hi)) begin
            dnum      <= 64'(vfree - 64'(lim_hi));
            clamp_sub <= 1'b1;
            vn        <= 64'(lim_hi);
            state     <= ST_UDIV;
          end else if (g != 0 && vfree < 64'(lim_lo)) begin
            dnum      <= 64'(64'(lim_lo) - vfree);
            clamp_sub <= 1'b0;
            vn        <= 64'(lim_lo);
            state     <= ST_UDIV;
          end else begin
            un    <= 64'(u);
            vn    <= vfree;
            state <= ST_X1;
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state_value             <= sat32(acc);
            state_slope             <= sat32(vn);
            out_data.filtered_value <= sat32(acc);
            out_data.derivative     <= sat32(vn);
            out_valid               <= 1'b1;
            state                   <= ST_IDLE;
          end
        end

        // Steps on the shared unit: issue once, then take the result.
        default: begin
          if (!issued) begin
            alu_start <= 1'b1;
            issued    <= 1'b1;
          end else if (alu_rsp.done) begin
            issued <= 1'b0;
            unique case (state)
              ST_TAU: begin
                tau <= alu_rsp.res[TAUW-1:0];
                if (alu_rsp.res[63:0] >= TAU_MAX) begin
                  p     <= '0;
                  s     <= '0;
                  g     <= '0;
                  h     <= '0;
                  state <= ST_W1;
                end else begin
                  n     <= alu_rsp.res[FRAC_BITS +: 6];
                  state <= ST_FD;
                end
              end
              ST_FD: begin
                fdf <= alu_rsp.res[FRAC_BITS-1:0];
                if (prod_sh >= 64'(EXP_TABLE_DEPTH)) begin
                  idx <= IDXW'(EXP_TABLE_DEPTH - 1);
                end else begin
                  idx <= prod_sh[IDXW-1:0];
                end
                state <= ST_R;
              end
              ST_R: begin
                r     <= 30'(alu_rsp.res >> R_SH);
                rom_q <= EXP_ROM[idx];
                state <= ST_R2;
              end
              ST_R2: begin
                r2    <= alu_rsp.res[EXP_Q +: 30];
                state <= ST_R3;
              end
              ST_R3: begin
                r3    <= alu_rsp.res[EXP_Q +: 30];
                state <= ST_R6;
              end
              ST_R6: begin
                poly  <= (31'd1 << EXP_Q) - 31'(r) + 31'(r2 >> 1)
                         - 31'(alu_rsp.res >> SIX_SH);
                state <= ST_M0;
              end
              ST_M0: begin
                m <= m_res;
                if (n == 6'd0) begin
                  e <= e_new;
                  if (e_new == '0) begin
                    p     <= '0;
                    s     <= '0;
                    g     <= '0;
                    h     <= '0;
                    state <= ST_W1;
                  end else begin
                    state <= ST_P;
                  end
                end else begin
                  state <= ST_MLOOP;
                end
              end
              // One multiply by exp(-1) for each whole time constant.
              ST_MLOOP: begin
                m <= m_res;
                n <= n - 6'd1;
                if (n == 6'd1) begin
                  e <= e_new;
                  if (e_new == '0) begin
                    p     <= '0;
                    s     <= '0;
                    g     <= '0;
                    h     <= '0;
                    state <= ST_W1;
                  end else begin
                    state <= ST_P;
                  end
                end
              end
              ST_P: begin
                p     <= $signed(prod_sh);
                state <= ST_S;
              end
              ST_S: begin
                s     <= (64'(tau) > ONE) ? -$signed(prod_sh) : $signed(prod_sh);
                state <= ST_G1;
              end
              ST_G1: begin
                tmp   <= prod_sh;
                state <= ST_G2;
              end
              ST_G2: begin
                tmp   <= alu_rsp.res[63:0];
                state <= ST_G3;
              end
              ST_G3: begin
                g     <= $signed(alu_rsp.res[63:0]);
                state <= ST_H1;
              end
              ST_H1: begin
                tmp   <= alu_rsp.res[63:0];
                state <= ST_H2;
              end
              ST_H2: begin
                h     <= $signed(64'(alu_rsp.res >> US_SH));
                state <= ST_W1;
              end
              ST_W1: begin
                acc   <= wres;
                state <= ST_W2;
              end
              ST_W2: begin
                acc   <= sadd62(acc, wres);
                state <= ST_W3;
              end
              ST_W3: begin
                vfree <= sadd62(acc, wres);
                state <= ST_CLAMP;
              end
              ST_UDIV: begin
                un    <= clamp_sub ? 64'(u) - $signed(qsat) : 64'(u) + $signed(qsat);
                state <= ST_X1;
              end
              ST_X1: begin
                acc   <= wres;
                state <= ST_X2;
              end
              ST_X2: begin
                acc   <= sadd62(acc, wres);
                state <= ST_X3;
              end
              ST_X3: begin
                acc   <= sadd62(acc, wres);
                state <= ST_DONE;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result from the shared unit only arrives for an issued step.
  a_done_issued: assert property (@(posedge clk) disable iff (rst) alu_rsp.done |-> issued)
    else $error("unit result without an issued step");
  // An update is only under way once a first sample has been taken.
  a_busy_started: assert property (@(posedge clk) disable iff (rst)
      (state != ST_IDLE) |-> started)
    else $error("update running before a first sample");
  // Once started, the filter stays started until reset.
  a_started_holds: assert property (@(posedge clk) disable iff (rst) started |=> started)
    else $error("started flag dropped");
`endif

endmodule

`default_nettype wire
